// File: design/drgpq_pkg.sv
// Package for the deduplicating publish queue: widths, command, status, lane and
// class codes and the slot record. No dependencies.
package drgpq_pkg;

  localparam int unsigned DefaultDepth = 64;
  localparam int unsigned SlotW = 32 + 48 + 32 + 32 + 32 + 64 + 2 + 3;

  localparam logic [3:0] CMD_ENQ_DEF = 4'd0;
  localparam logic [3:0] CMD_ENQ_LANE = 4'd1;
  localparam logic [3:0] CMD_REQ_FRONT = 4'd2;
  localparam logic [3:0] CMD_REQ_BACK = 4'd3;
  localparam logic [3:0] CMD_POP = 4'd4;
  localparam logic [3:0] CMD_POP_CLASS = 4'd5;
  localparam logic [3:0] CMD_POP_COORD = 4'd6;
  localparam logic [3:0] CMD_POP_CRIT = 4'd7;
  localparam logic [3:0] CMD_POP_NONCRIT = 4'd8;
  localparam logic [3:0] CMD_CLEAR = 4'd9;
  localparam logic [3:0] CMD_CONTAINS = 4'd10;

  localparam logic [3:0] ST_QUEUED = 4'd0;
  localparam logic [3:0] ST_QUEUED_ED = 4'd1;
  localparam logic [3:0] ST_REPLACED = 4'd2;
  localparam logic [3:0] ST_PROMOTED = 4'd3;
  localparam logic [3:0] ST_STALE = 4'd4;
  localparam logic [3:0] ST_INVALID = 4'd5;
  localparam logic [3:0] ST_POPPED = 4'd6;
  localparam logic [3:0] ST_NONE = 4'd7;
  localparam logic [3:0] ST_DONE = 4'd8;
  localparam logic [3:0] ST_PRESENT = 4'd9;
  localparam logic [3:0] ST_ABSENT = 4'd10;
  localparam logic [3:0] ST_FULL = 4'd11;

  localparam logic [2:0] LANE_CACHE = 3'd0;
  localparam logic [2:0] LANE_CRIT = 3'd4;
  localparam logic [2:0] LANE_VIS = 3'd3;
  localparam logic [1:0] CLS_EDITED = 2'd0;
  localparam logic [1:0] CLS_COLL = 2'd1;
  localparam logic [1:0] CLS_VIS = 2'd2;

  typedef struct packed {
    logic [31:0] entry;
    logic [47:0] coord;
    logic [31:0] page;
    logic [31:0] gen;
    logic [31:0] frame;
    logic [63:0] fence;
    logic [1:0]  cls;
    logic [2:0]  lane;
  } slot_t;

endpackage

// File: design/drgpq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module drgpq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: design/dedup_ready_gated_publish_queue.sv
// Top level of the deduplicating, ready-gated publish queue.
// Depends on drgpq_pkg and drgpq_ram.
//
// Usage: one command transaction goes in on the s_axis group and exactly one
// result transaction comes out on m_axis. s_axis_tdata carries command,
// entry index, coordinate, page, generation, frame, fence, class and lane.
// The queue lives in one RAM of QUEUE_DEPTH slots, slot 0 is the front.
// Each command is worked by a small sequencer around the single RAM:
//   - a search pass reads slots 0..occupancy-1, one a cycle, comparing with
//     one shared comparator set (entry match, or pop filter plus readiness);
//   - a shift pass moves slots up or down, each by a read then a write,
//     to close a gap or open slot 0.
// s_axis_tready is low from acceptance until the result has been taken; the
// result waits in the output register while m_axis_tready is low, and the
// next command is not taken until it has gone. Reset empties the queue
// (occupancy zero) and drops any held result; the RAM needs no clearing.
module dedup_ready_gated_publish_queue
  import drgpq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DefaultDepth
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // command[3:0], entry_index[35:4], coord_x[51:36], coord_y[67:52],
  // coord_z[83:68], page_index[115:84], generation[147:116], frame[179:148],
  // fence[243:180], residency_class[245:244], streaming_lane[248:246], 0 pad
  input  logic [255:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[3:0], out_entry_index[35:4], out_coord_x[51:36], out_coord_y[67:52],
  // out_coord_z[83:68], out_page_index[115:84], out_generation[147:116],
  // out_ready_frame[179:148], out_ready_fence[243:180], out_class[245:244],
  // out_lane[248:246], 0 pad
  output logic [255:0] m_axis_tdata
);
  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned OW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [OW-1:0] FullCount = OW'(QUEUE_DEPTH);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_DECIDE = 7'b0000100,
    S_SHRD   = 7'b0001000,
    S_SHWR   = 7'b0010000,
    S_PUT    = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  state_t state;
  logic [3:0]    cmd;
  slot_t         item;
  logic [OW-1:0] occupancy;
  logic [OW-1:0] rd_idx;     // next slot address issued
  logic          rd_pend;    // rdata holds slot rd_idx-1
  logic          found;
  logic [AW-1:0] hit_idx;
  slot_t         hit;
  logic [3:0]    status;
  logic          out_pop;
  // shift control: up=remove gap at sh_idx, down=open slot 0
  logic          sh_up;
  logic [OW-1:0] sh_idx, sh_end;
  logic          do_ins, ins_front;
  slot_t         ins_item;
  logic [3:0]    ins_status;
  logic [OW-1:0] occ_after;

  // RAM port
  logic          we;
  logic [AW-1:0] waddr, raddr;
  slot_t         wdata, rdata_s;
  logic [SlotW-1:0] rdata;

  drgpq_ram #(.Width(SlotW), .Depth(QUEUE_DEPTH)) u_ram (
    .clk, .we, .waddr, .wdata(wdata), .raddr, .rdata
  );
  assign rdata_s = slot_t'(rdata);

  // unpack input
  slot_t in_item;
  logic [3:0] in_cmd;
  logic [2:0] in_lane_sat;
  always_comb begin
    in_cmd = s_axis_tdata[3:0];
    in_lane_sat = (s_axis_tdata[248:246] > LANE_CRIT) ? LANE_CRIT : s_axis_tdata[248:246];
    in_item.entry = s_axis_tdata[35:4];
    in_item.coord = s_axis_tdata[83:36];
    in_item.page  = s_axis_tdata[115:84];
    in_item.gen   = s_axis_tdata[147:116];
    in_item.frame = s_axis_tdata[179:148];
    in_item.fence = s_axis_tdata[243:180];
    in_item.cls   = s_axis_tdata[245:244];
    in_item.lane  = in_lane_sat;
    if (in_cmd == CMD_ENQ_DEF) begin
      in_item.lane = (s_axis_tdata[245:244] <= CLS_COLL) ? LANE_CRIT :
                     ((s_axis_tdata[245:244] == CLS_VIS) ? LANE_VIS : LANE_CACHE);
    end
  end

  logic item_valid;
  assign item_valid = item.entry != '1 && item.page != 32'hFFFF_FFFF &&
                      item.page != 32'hFFFF_FFFE && item.gen != '0;

  logic is_pop;
  assign is_pop = cmd inside {CMD_POP, CMD_POP_CLASS, CMD_POP_COORD, CMD_POP_CRIT,
                              CMD_POP_NONCRIT};

  // shared compare unit on the slot just read
  logic crit, filt, rdy, match;
  always_comb begin
    crit = rdata_s.cls == CLS_EDITED || rdata_s.cls == CLS_COLL ||
           rdata_s.lane == LANE_CRIT || rdata_s.lane == LANE_VIS;
    case (cmd)
      CMD_POP_CLASS:   filt = rdata_s.cls == item.cls;
      CMD_POP_COORD:   filt = rdata_s.coord == item.coord;
      CMD_POP_CRIT:    filt = crit;
      CMD_POP_NONCRIT: filt = !crit;
      default:         filt = 1'b1;
    endcase
    rdy = item.frame >= rdata_s.frame &&
          (rdata_s.fence == '0 || item.fence >= rdata_s.fence);
    match = is_pop ? (filt && rdy) : (rdata_s.entry == item.entry);
  end

  // duplicate resolution from the found slot
  slot_t merged;
  logic  was_ed, is_ed;
  always_comb begin
    was_ed = hit.cls == CLS_EDITED;
    is_ed  = item.cls == CLS_EDITED;
    merged = item;
    if (was_ed) merged.cls = CLS_EDITED;
    if (hit.lane > item.lane) merged.lane = hit.lane;
    if (merged.cls == CLS_EDITED) merged.lane = LANE_CRIT;
  end

  // outcome of a command once the search is over
  state_t     dec_state;
  logic [3:0] dec_status, dec_ins_status;
  logic       dec_pop, dec_ins, dec_front, dec_remove, dec_open;
  slot_t      dec_item;
  always_comb begin
    dec_state = S_OUT;
    dec_status = ST_INVALID;
    dec_ins_status = ST_DONE;
    dec_pop = 1'b0;
    dec_ins = 1'b0;
    dec_front = 1'b0;
    dec_remove = 1'b0;
    dec_open = 1'b0;
    dec_item = item;
    if (cmd == CMD_CLEAR) begin
      dec_status = ST_DONE;
    end else if (cmd == CMD_CONTAINS) begin
      dec_status = found ? ST_PRESENT : ST_ABSENT;
    end else if (is_pop) begin
      if (found) begin
        dec_status = ST_POPPED;
        dec_pop = 1'b1;
        dec_remove = 1'b1;
        dec_state = S_SHRD;
      end else begin
        dec_status = ST_NONE;
      end
    end else if (cmd > CMD_CONTAINS || !item_valid) begin
      dec_status = ST_INVALID;
    end else if (cmd == CMD_ENQ_DEF || cmd == CMD_ENQ_LANE) begin
      if (!found) begin
        if (occupancy == FullCount) begin
          dec_status = ST_FULL;
        end else begin
          // new entry: edited ones open slot 0, others go to the back
          dec_ins = 1'b1;
          dec_front = is_ed;
          dec_ins_status = is_ed ? ST_QUEUED_ED : ST_QUEUED;
          dec_open = is_ed;
          dec_state = is_ed ? S_SHRD : S_PUT;
        end
      end else if (item.gen < hit.gen ||
                   (item.gen == hit.gen &&
                    (item.coord != hit.coord || item.page != hit.page))) begin
        dec_status = ST_STALE;
      end else begin
        dec_ins = 1'b1;
        dec_item = merged;
        dec_front = merged.cls == CLS_EDITED;
        dec_ins_status = (is_ed && !was_ed) ? ST_PROMOTED : ST_REPLACED;
        dec_remove = 1'b1;
        dec_state = S_SHRD;
      end
    end else begin
      // requeue
      if (found && (item.coord != hit.coord || item.page != hit.page ||
                    item.gen < hit.gen)) begin
        dec_status = ST_STALE;
      end else if (!found && occupancy == FullCount) begin
        dec_status = ST_FULL;
      end else begin
        dec_ins = 1'b1;
        dec_front = cmd == CMD_REQ_FRONT;
        dec_ins_status = ST_DONE;
        dec_remove = found;
        dec_open = !found && cmd == CMD_REQ_FRONT;
        dec_state = (found || cmd == CMD_REQ_FRONT) ? S_SHRD : S_PUT;
      end
    end
  end

  // result word, zero beyond status unless an entry was popped
  logic [255:0] out_data;
  always_comb begin
    out_data = '0;
    out_data[3:0] = status;
    if (out_pop) begin
      out_data[35:4]    = hit.entry;
      out_data[83:36]   = hit.coord;
      out_data[115:84]  = hit.page;
      out_data[147:116] = hit.gen;
      out_data[179:148] = hit.frame;
      out_data[243:180] = hit.fence;
      out_data[245:244] = hit.cls;
      out_data[248:246] = hit.lane;
    end
  end

  assign s_axis_tready = state == S_IDLE && !m_axis_tvalid;

  always_comb begin
    we = 1'b0;
    waddr = sh_idx[AW-1:0];
    wdata = rdata_s;
    raddr = rd_idx[AW-1:0];
    case (state)
      S_SHRD: raddr = sh_up ? AW'(sh_idx + 1'b1) : AW'(sh_idx - 1'b1);
      S_SHWR: begin
        we = 1'b1;
      end
      S_PUT: begin
        we = 1'b1;
        waddr = ins_front ? '0 : occupancy[AW-1:0];
        wdata = ins_item;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      occupancy <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            cmd <= in_cmd;
            item <= in_item;
            rd_idx <= '0;
            rd_pend <= 1'b0;
            found <= 1'b0;
            out_pop <= 1'b0;
            do_ins <= 1'b0;
            sh_idx <= '0;
            sh_end <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_pend && match) begin
            found <= 1'b1;
            hit <= rdata_s;
            hit_idx <= AW'(rd_idx - 1'b1);
            state <= S_DECIDE;
          end else if (rd_idx >= occupancy || cmd == CMD_CLEAR || cmd > CMD_CONTAINS ||
                       (!is_pop && cmd != CMD_CONTAINS && !item_valid)) begin
            state <= S_DECIDE;
          end else begin
            rd_idx <= rd_idx + 1'b1;
            rd_pend <= 1'b1;
          end
        end
        S_DECIDE: begin
          state <= dec_state;
          status <= dec_status;
          out_pop <= dec_pop;
          do_ins <= dec_ins;
          ins_item <= dec_item;
          ins_front <= dec_front;
          ins_status <= dec_ins_status;
          occ_after <= dec_remove ? occupancy - 1'b1 : occupancy;
          sh_up <= !dec_open;
          sh_idx <= dec_open ? occupancy : OW'(hit_idx);
          sh_end <= dec_open ? '0 : occupancy - 1'b1;
          if (cmd == CMD_CLEAR) occupancy <= '0;
        end
        S_SHRD: begin
          if (sh_idx == sh_end) begin
            // pass over; after a removal, maybe open front next
            occupancy <= occ_after;
            if (sh_up && do_ins && ins_front && occ_after != '0) begin
              sh_up <= 1'b0;
              sh_idx <= occ_after;
              sh_end <= '0;
            end else if (do_ins) begin
              state <= S_PUT;
            end else begin
              state <= S_OUT;
            end
          end else begin
            state <= S_SHWR;
          end
        end
        S_SHWR: begin
          sh_idx <= sh_up ? sh_idx + 1'b1 : sh_idx - 1'b1;
          state <= S_SHRD;
        end
        S_PUT: begin
          occupancy <= occupancy + 1'b1;
          status <= ins_status;
          state <= S_OUT;
        end
        S_OUT: begin
          m_axis_tvalid <= 1'b1;
          m_axis_tdata <= out_data;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
